@@ sv/sukt_pkg.sv @@
// Package for the sorted unique-key table: command and status codes,
// request, response and table-entry types. No dependencies.
`default_nettype none

package sukt_pkg;

    // Command codes carried by a request.
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_FIND   = 2'd1,
        CMD_READ   = 2'd2,
        CMD_DUMP   = 2'd3
    } cmd_t;

    // Status codes carried by a response.
    typedef enum logic [2:0] {
        STAT_INSERTED  = 3'd0,
        STAT_DUPLICATE = 3'd1,
        STAT_FOUND     = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_FULL      = 3'd4,
        STAT_DUMP      = 3'd5
    } status_t;

    // Width of the position, index and count fields on the ports.
    localparam int PosW = 5;

    // One stored table entry.
    typedef struct packed {
        logic signed [31:0] key;
        logic               kind;
        logic [31:0]        price;
    } entry_t;

    // Control that the top level hands to every cell.
    typedef struct packed {
        logic occupied;
        logic insert_en;
    } cell_ctl_t;

    // Compare results that every cell reports back.
    typedef struct packed {
        logic less;
        logic eq;
    } cell_flags_t;

    // Request payload.
    typedef struct packed {
        cmd_t               command;
        logic signed [31:0] key;
        logic               kind;
        logic [31:0]        price_bits;
        logic [PosW-1:0]    index;
    } req_t;

    // Response payload.
    typedef struct packed {
        status_t            status;
        logic [PosW-1:0]    position;
        logic signed [31:0] entry_key;
        logic               entry_kind;
        logic [31:0]        entry_price;
        logic [PosW-1:0]    entry_count;
        logic               last;
    } rsp_t;

endpackage

`default_nettype wire

@@ sv/sukt_cell.sv @@
// One cell of the sorted table chain: holds a single entry, compares it
// against the broadcast key and shifts in from its left neighbor on insert.
// Depends on sukt_pkg.
`default_nettype none

module sukt_cell
    import sukt_pkg::*;
(
    input  wire logic        clk,
    input  wire cell_ctl_t   ctl,
    input  wire logic        left_less,
    input  wire entry_t      left_entry,
    input  wire entry_t      new_entry,
    output      cell_flags_t flags,
    output      entry_t      entry
);

    entry_t entry_reg;
    entry_t entry_next;

    // Signed compare of the held key against the broadcast key.
    always_comb
    begin
        flags.less = ctl.occupied && (entry_reg.key < new_entry.key);
        flags.eq   = ctl.occupied && (entry_reg.key == new_entry.key);
    end

    // On insert, cells right of the insertion point take their left
    // neighbor, and the cell at the insertion point takes the new entry.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.insert_en)
        begin
            if (!left_less)
            begin
                entry_next = left_entry;
            end
            else if (!flags.less)
            begin
                entry_next = new_entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

@@ sv/sorted_unique_key_table_top.sv @@
// Sorted unique-key table: top level with the cell chain, the response
// register and the dump sequencer. Depends on sukt_pkg and sukt_cell.
//
// Usage: requests arrive on req_valid/req_ready with a req_t payload and
// responses leave on rsp_valid/rsp_ready with an rsp_t payload. Entries
// are kept in ascending signed key order in a chain of CAPACITY cells.
// Every cell compares its key with the request key at once, so for insert,
// find and read the single response is loaded into the output register at
// the edge that accepts the request, one request per cycle while the
// receiver keeps up. A dump of N entries produces N responses, one per
// cycle while the receiver keeps up, and blocks new requests until the
// last one is loaded; an empty dump gives one response.
// Reset clears the entry count, the sequencer and the response valid;
// the cell contents are not cleared and are only read below the count.
// When the receiver stalls, the response register holds its response and
// req_ready drops until the register is free again.
`default_nettype none

module sorted_unique_key_table_top
    import sukt_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output      logic req_ready,
    input  wire req_t req,
    output      logic rsp_valid,
    input  wire logic rsp_ready,
    output      rsp_t rsp
);

    localparam int IdxW = $clog2(CAPACITY);
    localparam int CntW = $clog2(CAPACITY + 1);
    localparam int CmpW = (CntW > PosW) ? CntW : PosW;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } state_t;

    state_t          state_reg, state_next;
    logic [CntW-1:0] fill_reg, fill_next;
    logic [IdxW-1:0] dump_idx_reg, dump_idx_next;
    logic            rsp_valid_reg, rsp_valid_next;
    rsp_t            rsp_reg, rsp_next;

    cell_flags_t     flags [CAPACITY];
    entry_t          cell_entry [CAPACITY];
    logic [CAPACITY-1:0] less_vec;
    logic [CAPACITY-1:0] eq_vec;
    logic [CAPACITY-1:0] ins_vec;
    logic [CAPACITY-1:0] sel_vec;
    logic            insert_en;
    entry_t          new_entry;
    entry_t          sel_entry;
    logic [IdxW-1:0] hit_pos;
    logic [IdxW-1:0] ins_pos;
    logic            any_eq;
    logic            table_full;
    logic            read_ok;
    logic            slot_free;

    assign new_entry.key   = req.key;
    assign new_entry.kind  = req.kind;
    assign new_entry.price = req.price_bits;

    // Chain of cells; cell zero sees an always-smaller left neighbor.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        cell_ctl_t ctl;
        logic      left_less;
        entry_t    left_entry;

        assign ctl.occupied  = (CntW'(g) < fill_reg);
        assign ctl.insert_en = insert_en;

        if (g == 0)
        begin : g_first
            assign left_less  = 1'b1;
            assign left_entry = new_entry;
        end
        else
        begin : g_rest
            assign left_less  = less_vec[g-1];
            assign left_entry = cell_entry[g-1];
        end

        sukt_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .left_less  (left_less),
            .left_entry (left_entry),
            .new_entry  (new_entry),
            .flags      (flags[g]),
            .entry      (cell_entry[g])
        );

        assign less_vec[g] = flags[g].less;
        assign eq_vec[g]   = flags[g].eq;
        assign ins_vec[g]  = !less_vec[g] && left_less;
    end

    assign any_eq     = |eq_vec;
    assign table_full = (fill_reg == CntW'(CAPACITY));
    assign read_ok    = (CmpW'(req.index) < CmpW'(fill_reg));
    assign slot_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready  = (state_reg == S_IDLE) && slot_free;

    // Encode the one-hot hit and insertion-point vectors.
    always_comb
    begin
        hit_pos = '0;
        ins_pos = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (eq_vec[i])
            begin
                hit_pos = hit_pos | IdxW'(i);
            end
            if (ins_vec[i])
            begin
                ins_pos = ins_pos | IdxW'(i);
            end
        end
    end

    // Choose which cell feeds the response payload.
    always_comb
    begin
        sel_vec = '0;
        if (state_reg == S_DUMP)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                sel_vec[i] = (dump_idx_reg == IdxW'(i));
            end
        end
        else
        begin
            case (req.command) inside
                CMD_INSERT, CMD_FIND:
                begin
                    sel_vec = eq_vec;
                end
                CMD_READ:
                begin
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        sel_vec[i] = (CmpW'(req.index) == CmpW'(i));
                    end
                end
                default:
                begin
                    sel_vec[0] = 1'b1;
                end
            endcase
        end
    end

    // AND-OR selection of the chosen cell's entry.
    always_comb
    begin
        sel_entry = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (sel_vec[i])
            begin
                sel_entry = sel_entry | cell_entry[i];
            end
        end
    end

    // Request handling and dump sequencer.
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        dump_idx_next  = dump_idx_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        insert_en      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid && slot_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next             = '0;
                    rsp_next.last        = 1'b1;
                    rsp_next.entry_count = PosW'(fill_reg);
                    case (req.command)
                        CMD_INSERT:
                        begin
                            if (any_eq)
                            begin
                                rsp_next.status      = STAT_DUPLICATE;
                                rsp_next.position    = PosW'(hit_pos);
                                rsp_next.entry_key   = sel_entry.key;
                                rsp_next.entry_kind  = sel_entry.kind;
                                rsp_next.entry_price = sel_entry.price;
                            end
                            else if (table_full)
                            begin
                                rsp_next.status = STAT_FULL;
                            end
                            else
                            begin
                                insert_en            = 1'b1;
                                fill_next            = fill_reg + CntW'(1);
                                rsp_next.status      = STAT_INSERTED;
                                rsp_next.position    = PosW'(ins_pos);
                                rsp_next.entry_key   = req.key;
                                rsp_next.entry_kind  = req.kind;
                                rsp_next.entry_price = req.price_bits;
                                rsp_next.entry_count = PosW'(fill_next);
                            end
                        end
                        CMD_FIND:
                        begin
                            if (any_eq)
                            begin
                                rsp_next.status      = STAT_FOUND;
                                rsp_next.position    = PosW'(hit_pos);
                                rsp_next.entry_key   = sel_entry.key;
                                rsp_next.entry_kind  = sel_entry.kind;
                                rsp_next.entry_price = sel_entry.price;
                            end
                            else
                            begin
                                rsp_next.status = STAT_NOT_FOUND;
                            end
                        end
                        CMD_READ:
                        begin
                            if (read_ok)
                            begin
                                rsp_next.status      = STAT_FOUND;
                                rsp_next.position    = req.index;
                                rsp_next.entry_key   = sel_entry.key;
                                rsp_next.entry_kind  = sel_entry.kind;
                                rsp_next.entry_price = sel_entry.price;
                            end
                            else
                            begin
                                rsp_next.status = STAT_NOT_FOUND;
                            end
                        end
                        default:
                        begin
                            rsp_next.status = STAT_DUMP;
                            if (fill_reg != '0)
                            begin
                                rsp_next.entry_key   = sel_entry.key;
                                rsp_next.entry_kind  = sel_entry.kind;
                                rsp_next.entry_price = sel_entry.price;
                                rsp_next.last        = (fill_reg == CntW'(1));
                                if (fill_reg != CntW'(1))
                                begin
                                    state_next    = S_DUMP;
                                    dump_idx_next = IdxW'(1);
                                end
                            end
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                if (slot_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next             = '0;
                    rsp_next.status      = STAT_DUMP;
                    rsp_next.position    = PosW'(dump_idx_reg);
                    rsp_next.entry_key   = sel_entry.key;
                    rsp_next.entry_kind  = sel_entry.kind;
                    rsp_next.entry_price = sel_entry.price;
                    rsp_next.entry_count = PosW'(fill_reg);
                    rsp_next.last = ((CntW'(dump_idx_reg) + CntW'(1)) == fill_reg);
                    if (rsp_next.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        dump_idx_next = dump_idx_reg + IdxW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            dump_idx_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            dump_idx_reg  <= dump_idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Response payload register.
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for the sorted unique-key table: directed stimulus rows, then
// random requests, checked against a shadow model of the table or a row's own response.
// Depends on sukt_pkg and sorted_unique_key_table_top.
`default_nettype none

module tb_top;
    import sukt_pkg::*;

    localparam int TableDepth = 16;
    localparam int RandomRequests = 295;
    localparam int DrainLimit = 50000;
    localparam int SettleCycles = 10;

    // One row of the directed stimulus table.
    typedef struct {
        req_t r;
        bit   typed;
        rsp_t want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    // Shadow copy of the table contents.
    entry_t shadow [TableDepth];
    int shadow_fill = 0;

    // Responses still owed by the block, oldest first.
    rsp_t expected_rsp [$];
    rsp_t step_rsp [$];
    stim_row_t stim_rows [$];
    rsp_t oldest;

    int errors = 0;
    int burst_left = 0;
    int n_insert = 0;
    int n_find = 0;
    int n_read = 0;
    int n_dump = 0;
    int n_full = 0;
    int n_dup = 0;
    int n_rsp = 0;
    int max_fill = 0;

    sorted_unique_key_table_top #(
        .CAPACITY(TableDepth)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

    always #2 clk = ~clk;

    // Build one response from the shadow state after the step.
    function automatic rsp_t make_rsp(input status_t st, input int pos, input entry_t e,
                                      input bit lst);
        rsp_t o;
        o.status = st;
        o.position = PosW'(pos);
        o.entry_key = e.key;
        o.entry_kind = e.kind;
        o.entry_price = e.price;
        o.entry_count = PosW'(shadow_fill);
        o.last = lst;
        return o;
    endfunction

    // Apply one request to the shadow table and collect its responses in step_rsp.
    function automatic void table_step(input req_t r);
        int hit;
        int pos;
        step_rsp.delete();
        hit = -1;
        pos = 0;
        case (r.command)
            CMD_INSERT:
            begin
                n_insert++;
                for (int i = 0; i < shadow_fill && hit < 0; i++)
                begin
                    if (shadow[i].key == r.key)
                        hit = i;
                    else if (shadow[i].key < r.key)
                        pos = i + 1;
                end
                if (hit >= 0)
                begin
                    n_dup++;
                    step_rsp.push_back(make_rsp(STAT_DUPLICATE, hit, shadow[hit], 1'b1));
                end
                else if (shadow_fill >= TableDepth)
                begin
                    n_full++;
                    step_rsp.push_back(make_rsp(STAT_FULL, 0, '0, 1'b1));
                end
                else
                begin
                    // Open a slot at the sorted position and store the new entry.
                    for (int i = shadow_fill; i > pos; i--)
                        shadow[i] = shadow[i - 1];
                    shadow[pos].key = r.key;
                    shadow[pos].kind = r.kind;
                    shadow[pos].price = r.price_bits;
                    shadow_fill++;
                    if (shadow_fill > max_fill)
                        max_fill = shadow_fill;
                    step_rsp.push_back(make_rsp(STAT_INSERTED, pos, shadow[pos], 1'b1));
                end
            end
            CMD_FIND:
            begin
                n_find++;
                for (int i = 0; i < shadow_fill && hit < 0; i++)
                    if (shadow[i].key == r.key)
                        hit = i;
                if (hit >= 0)
                    step_rsp.push_back(make_rsp(STAT_FOUND, hit, shadow[hit], 1'b1));
                else
                    step_rsp.push_back(make_rsp(STAT_NOT_FOUND, 0, '0, 1'b1));
            end
            CMD_READ:
            begin
                n_read++;
                if (int'(r.index) < shadow_fill)
                    step_rsp.push_back(make_rsp(STAT_FOUND, int'(r.index),
                                                shadow[int'(r.index)], 1'b1));
                else
                    step_rsp.push_back(make_rsp(STAT_NOT_FOUND, 0, '0, 1'b1));
            end
            default:
            begin
                n_dump++;
                if (shadow_fill == 0)
                    step_rsp.push_back(make_rsp(STAT_DUMP, 0, '0, 1'b1));
                else
                    for (int i = 0; i < shadow_fill; i++)
                        step_rsp.push_back(make_rsp(STAT_DUMP, i, shadow[i],
                                                    i == shadow_fill - 1));
            end
        endcase
    endfunction

    // Random request that mostly reuses keys held in the table or their neighbors.
    function automatic req_t random_request();
        req_t r;
        int pick;
        int sel;
        r.key = $urandom;
        r.kind = 1'($urandom_range(0, 1));
        r.price_bits = $urandom;
        r.index = PosW'($urandom_range(0, 31));
        pick = $urandom_range(0, 99);
        if (pick < 35)
            r.command = CMD_INSERT;
        else if (pick < 65)
            r.command = CMD_FIND;
        else if (pick < 90)
            r.command = CMD_READ;
        else
            r.command = CMD_DUMP;
        sel = $urandom_range(0, 99);
        if (sel < 40 && shadow_fill > 0)
            r.key = shadow[$urandom_range(0, shadow_fill - 1)].key;
        else if (sel < 55 && shadow_fill > 0)
            r.key = shadow[$urandom_range(0, shadow_fill - 1)].key
                    + ($urandom_range(0, 1) ? 32'sd1 : -32'sd1);
        else if (sel < 70)
        begin
            case ($urandom_range(0, 4))
                0: r.key = 32'sh8000_0000;
                1: r.key = 32'sh7fff_ffff;
                2: r.key = 32'sd0;
                3: r.key = -32'sd1;
                default: r.key = 32'sd1;
            endcase
        end
        if ($urandom_range(0, 9) == 0)
            r.price_bits = $urandom_range(0, 1) ? 32'h0000_0000 : 32'hffff_ffff;
        if (r.command == CMD_READ && shadow_fill > 0 && $urandom_range(0, 9) < 6)
            r.index = PosW'($urandom_range(0, shadow_fill - 1));
        return r;
    endfunction

    // Append one row to the directed stimulus table.
    task automatic add_row(input cmd_t c, input logic [31:0] k, input logic kd,
                           input logic [31:0] p, input int idx, input bit typed,
                           input status_t st, input int pos, input logic [31:0] ek,
                           input logic ekd, input logic [31:0] ep, input int cnt);
        stim_row_t row;
        row.r.command = c;
        row.r.key = k;
        row.r.kind = kd;
        row.r.price_bits = p;
        row.r.index = PosW'(idx);
        row.typed = typed;
        row.want.status = st;
        row.want.position = PosW'(pos);
        row.want.entry_key = ek;
        row.want.entry_kind = ekd;
        row.want.entry_price = ep;
        row.want.entry_count = PosW'(cnt);
        row.want.last = 1'b1;
        stim_rows.push_back(row);
    endtask

    // Offer one request in bursts with random gaps and wait for its handshake.
    task automatic send_request(input req_t r);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    // Compare one response field and report a mismatch.
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    // Response checker: every accepted response against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            n_rsp++;
            if (expected_rsp.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected response, expected none, actual %h", $time, rsp);
            end
            else
            begin
                oldest = expected_rsp.pop_front();
                check_field("status", 32'(oldest.status), 32'(rsp.status));
                check_field("position", 32'(oldest.position), 32'(rsp.position));
                check_field("entry_key", oldest.entry_key, rsp.entry_key);
                check_field("entry_kind", 32'(oldest.entry_kind), 32'(rsp.entry_kind));
                check_field("entry_price", oldest.entry_price, rsp.entry_price);
                check_field("entry_count", 32'(oldest.entry_count), 32'(rsp.entry_count));
                check_field("last", 32'(oldest.last), 32'(rsp.last));
            end
        end
    end

    // Receiver: changing ready patterns, plus long hold-offs that back up the block.
    initial
    begin : receiver
        int cycle;
        int mode;
        int mode_left;
        int hold_left;
        cycle = 0;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
                cycle++;
            if (cycle == 150 || cycle == 900)
                hold_left = 120;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 60);
                end
                mode_left--;
                case (mode)
                    0: rsp_ready <= 1'b1;
                    1: rsp_ready <= 1'($urandom_range(0, 1));
                    2: rsp_ready <= ($urandom_range(0, 3) != 0);
                    default: rsp_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Run limit.
    initial
    begin
        #(4 * 400000);
        $display("== FAIL ==");
        $finish;
    end

    // Main sequence: reset, directed table, random requests, drain and verdict.
    initial
    begin
        req_t r;
        int drain;

        // Directed rows: empty table, extremes of the key, duplicates and misses.
        add_row(CMD_DUMP, 32'd0, 1'b0, 32'd0, 0, 1,
                STAT_DUMP, 0, 32'd0, 1'b0, 32'd0, 0);
        add_row(CMD_FIND, 32'd5, 1'b0, 32'd0, 0, 1,
                STAT_NOT_FOUND, 0, 32'd0, 1'b0, 32'd0, 0);
        add_row(CMD_READ, 32'd0, 1'b0, 32'd0, 0, 1,
                STAT_NOT_FOUND, 0, 32'd0, 1'b0, 32'd0, 0);
        add_row(CMD_INSERT, 32'd0, 1'b0, 32'd0, 0, 1,
                STAT_INSERTED, 0, 32'd0, 1'b0, 32'd0, 1);
        add_row(CMD_INSERT, 32'h7fff_ffff, 1'b1, 32'hffff_ffff, 0, 1,
                STAT_INSERTED, 1, 32'h7fff_ffff, 1'b1, 32'hffff_ffff, 2);
        add_row(CMD_INSERT, 32'h8000_0000, 1'b1, 32'h3f80_0000, 0, 1,
                STAT_INSERTED, 0, 32'h8000_0000, 1'b1, 32'h3f80_0000, 3);
        add_row(CMD_INSERT, 32'd0, 1'b1, 32'h0000_1234, 0, 1,
                STAT_DUPLICATE, 1, 32'd0, 1'b0, 32'd0, 3);
        add_row(CMD_FIND, 32'h7fff_ffff, 1'b0, 32'd0, 0, 1,
                STAT_FOUND, 2, 32'h7fff_ffff, 1'b1, 32'hffff_ffff, 3);
        add_row(CMD_READ, 32'd0, 1'b0, 32'd0, 3, 1,
                STAT_NOT_FOUND, 0, 32'd0, 1'b0, 32'd0, 3);
        add_row(CMD_READ, 32'd0, 1'b0, 32'd0, 31, 1,
                STAT_NOT_FOUND, 0, 32'd0, 1'b0, 32'd0, 3);
        add_row(CMD_FIND, 32'hffff_ffff, 1'b0, 32'd0, 0, 1,
                STAT_NOT_FOUND, 0, 32'd0, 1'b0, 32'd0, 3);
        add_row(CMD_INSERT, 32'hffff_ffff, 1'b0, 32'h4049_0fdb, 0, 0,
                STAT_INSERTED, 0, 32'd0, 1'b0, 32'd0, 0);
        add_row(CMD_READ, 32'd0, 1'b0, 32'd0, 1, 0,
                STAT_FOUND, 0, 32'd0, 1'b0, 32'd0, 0);
        add_row(CMD_INSERT, 32'd1, 1'b1, 32'hdead_beef, 0, 0,
                STAT_INSERTED, 0, 32'd0, 1'b0, 32'd0, 0);
        add_row(CMD_DUMP, 32'd0, 1'b0, 32'd0, 0, 0,
                STAT_DUMP, 0, 32'd0, 1'b0, 32'd0, 0);
        add_row(CMD_FIND, 32'h8000_0000, 1'b0, 32'd0, 0, 0,
                STAT_FOUND, 0, 32'd0, 1'b0, 32'd0, 0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: typed rows carry their own expectation.
        foreach (stim_rows[i])
        begin
            send_request(stim_rows[i].r);
            table_step(stim_rows[i].r);
            if (stim_rows[i].typed)
                expected_rsp.push_back(stim_rows[i].want);
            else
                foreach (step_rsp[j])
                    expected_rsp.push_back(step_rsp[j]);
        end

        // Random part: fills the table, then keeps hitting the full-table cases.
        for (int n = 0; n < RandomRequests; n++)
        begin
            r = random_request();
            send_request(r);
            table_step(r);
            foreach (step_rsp[j])
                expected_rsp.push_back(step_rsp[j]);
        end
        req_valid <= 1'b0;

        // Wait for every owed response, then wait out SettleCycles to catch strays.
        drain = 0;
        while (expected_rsp.size() != 0 && drain < DrainLimit)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (SettleCycles) @(posedge clk);
        if (expected_rsp.size() != 0)
        begin
            errors++;
            $display("%0t: %0d responses never arrived", $time, expected_rsp.size());
        end

        $display("Ran %0d requests (%0d insert, %0d find, %0d read, %0d dump), %0d responses.",
                 n_insert + n_find + n_read + n_dump, n_insert, n_find, n_read, n_dump, n_rsp);
        $display("Table peaked at %0d entries; %0d duplicate and %0d full-table inserts.",
                 max_fill, n_dup, n_full);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
sv/sukt_pkg.sv
sv/sukt_cell.sv
sv/sorted_unique_key_table_top.sv
test/tb_top.sv
